/* sv/arp_resolver_with_aging_cache_macros.svh */
// Assertion macros for the ARP resolver checker.
`ifndef ARP_RESOLVER_WITH_AGING_CACHE_MACROS_SVH
`define ARP_RESOLVER_WITH_AGING_CACHE_MACROS_SVH

// same-cycle implication
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/arpc_pkg.sv */
// Shared constants, types and command/status structs of the ARP resolver.
package arpc_pkg;

  localparam int CACHE_ENTRIES   = 16;
  localparam int REQUEST_ENTRIES = 8;
  localparam int WAITING_ENTRIES = 16;
  localparam int TAG_BITS        = 16;

  localparam int CW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int RW  = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
  localparam int WW  = (WAITING_ENTRIES > 1) ? $clog2(WAITING_ENTRIES) : 1;
  localparam int WCW = $clog2(WAITING_ENTRIES + 1);
  localparam int MAXE = (CACHE_ENTRIES > REQUEST_ENTRIES) ?
                        ((CACHE_ENTRIES > WAITING_ENTRIES) ? CACHE_ENTRIES : WAITING_ENTRIES) :
                        ((REQUEST_ENTRIES > WAITING_ENTRIES) ? REQUEST_ENTRIES : WAITING_ENTRIES);
  localparam int IW  = (MAXE > 1) ? $clog2(MAXE) : 1;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_IPV4 = 2'd0;
  localparam logic [1:0] KIND_ARP  = 2'd1;
  localparam logic [1:0] ARP_OP_REQUEST = 2'd1;

  localparam logic [2:0] ACT_FRAME     = 3'd0;
  localparam logic [2:0] ACT_ARP_REQ   = 3'd1;
  localparam logic [2:0] ACT_ARP_REPLY = 3'd2;
  localparam logic [2:0] ACT_DELIVER   = 3'd3;
  localparam logic [2:0] ACT_DROP      = 3'd4;

  localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CFG_OWN_MAC   = 2'd0;
  localparam logic [1:0] CFG_OWN_IP    = 2'd1;
  localparam logic [1:0] CFG_ENTRY_LT  = 2'd2;
  localparam logic [1:0] CFG_REQ_LT    = 2'd3;

  typedef struct packed {
    logic load;
    logic clr_idx;
    logic scan_c;
    logic scan_r;
    logic scan_w;
    logic do_send;
    logic do_learn;
    logic push_reply;
    logic push_deliver;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       deliver;
    logic       arp;
    logic       reply;
    logic       hit;
    logic       c_end;
    logic       r_end;
    logic       w_end;
  } sts_t;

endpackage

/* sv/arpc_ctrl.sv */
// Sequencer of the ARP resolver: steps each item through table scans.
module arpc_ctrl import arpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_CSCAN = 3'd2;
  localparam logic [2:0] S_RSCAN = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;
  localparam logic [2:0] S_LEARN = 3'd5;
  localparam logic [2:0] S_WSCAN = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_SEND, OP_TICK: state_nxt = S_CSCAN;
          OP_RECV: begin
            if (sts.deliver) begin
              cmd.push_deliver = 1'b1;
              state_nxt = S_FIN;
            end else if (sts.arp) begin
              cmd.push_reply = sts.reply;
              state_nxt = S_CSCAN;
            end else begin
              state_nxt = S_FIN;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_CSCAN: begin
        cmd.scan_c = 1'b1;
        if (sts.c_end) begin
          cmd.clr_idx = 1'b1;
          if (sts.op == OP_RECV) state_nxt = S_LEARN;
          else if (sts.op == OP_SEND && sts.hit) state_nxt = S_SEND;
          else state_nxt = S_RSCAN;
        end
      end
      S_RSCAN: begin
        cmd.scan_r = 1'b1;
        if (sts.r_end) begin
          cmd.clr_idx = 1'b1;
          state_nxt = (sts.op == OP_TICK) ? S_WSCAN : S_SEND;
        end
      end
      S_SEND: begin
        cmd.do_send = 1'b1;
        state_nxt = S_FIN;
      end
      S_LEARN: begin
        cmd.do_learn = 1'b1;
        state_nxt = S_WSCAN;
      end
      S_WSCAN: begin
        cmd.scan_w = 1'b1;
        if (sts.w_end) begin
          cmd.clr_idx = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

/* sv/arpc_dp.sv */
// Datapath of the ARP resolver: tables, scan trackers, result hold and output.
module arpc_dp import arpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_wdata,
  input  logic [1:0]          in_operation,
  input  logic [31:0]         in_hop_ip,
  input  logic [TAG_BITS-1:0] in_packet_tag,
  input  logic [47:0]         in_frame_dst_mac,
  input  logic [1:0]          in_frame_kind,
  input  logic                in_parse_ok,
  input  logic [1:0]          in_arp_op,
  input  logic [47:0]         in_arp_sender_mac,
  input  logic [31:0]         in_arp_sender_ip,
  input  logic [31:0]         in_arp_target_ip,
  input  logic [31:0]         in_elapsed_ms,
  output logic                out_strobe,
  output logic [2:0]          out_action,
  output logic [47:0]         out_dest_mac,
  output logic [31:0]         out_ask_ip,
  output logic [TAG_BITS-1:0] out_result_tag,
  output logic                out_last
);

  // configuration
  logic [47:0] own_mac_r, own_mac_nxt;
  logic [31:0] own_ip_r, own_ip_nxt, ent_lt_r, ent_lt_nxt, req_lt_r, req_lt_nxt;

  // latched item
  logic [1:0]          op_r, op_nxt;
  logic [31:0]         key_r, key_nxt, dt_r, dt_nxt;
  logic [47:0]         mac_r, mac_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                dlv_r, dlv_nxt, arp_r, arp_nxt, rep_r, rep_nxt;

  // tables
  logic [CACHE_ENTRIES-1:0]   c_val_r, c_val_nxt;
  logic [31:0]                c_ip_r  [CACHE_ENTRIES], c_ip_nxt  [CACHE_ENTRIES];
  logic [47:0]                c_mac_r [CACHE_ENTRIES], c_mac_nxt [CACHE_ENTRIES];
  logic [31:0]                c_ttl_r [CACHE_ENTRIES], c_ttl_nxt [CACHE_ENTRIES];
  logic [REQUEST_ENTRIES-1:0] r_val_r, r_val_nxt, kill_r, kill_nxt;
  logic [31:0]                r_ip_r  [REQUEST_ENTRIES], r_ip_nxt  [REQUEST_ENTRIES];
  logic [31:0]                r_ttl_r [REQUEST_ENTRIES], r_ttl_nxt [REQUEST_ENTRIES];
  logic [31:0]                w_ip_r  [WAITING_ENTRIES], w_ip_nxt  [WAITING_ENTRIES];
  logic [TAG_BITS-1:0]        w_tag_r [WAITING_ENTRIES], w_tag_nxt [WAITING_ENTRIES];
  logic [WCW-1:0]             wcnt_r, wcnt_nxt, wp_r, wp_nxt;

  // scan state
  logic [IW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt, free_r, free_nxt, outs_r, outs_nxt, rfree_r, rfree_nxt;
  logic [CW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt, min_idx_r, min_idx_nxt;
  logic [31:0]   min_ttl_r, min_ttl_nxt;
  logic [47:0]   hit_mac_r, hit_mac_nxt;
  logic [RW-1:0] rfree_idx_r, rfree_idx_nxt;

  // result hold and output
  logic                hold_v_r, hold_v_nxt;
  logic [2:0]          hold_act_r, hold_act_nxt;
  logic [47:0]         hold_mac_r, hold_mac_nxt;
  logic [31:0]         hold_ip_r, hold_ip_nxt;
  logic [TAG_BITS-1:0] hold_tag_r, hold_tag_nxt;
  logic                o_stb_r, o_stb_nxt, o_last_r, o_last_nxt;
  logic [2:0]          o_act_r, o_act_nxt;
  logic [47:0]         o_mac_r, o_mac_nxt;
  logic [31:0]         o_ip_r, o_ip_nxt;
  logic [TAG_BITS-1:0] o_tag_r, o_tag_nxt;

  logic                push;
  logic [2:0]          p_act;
  logic [47:0]         p_mac;
  logic [31:0]         p_ip;
  logic [TAG_BITS-1:0] p_tag;

  logic          first, dst_ok, in_use, killm, drop;
  logic [CW-1:0] ci, slot;
  logic [RW-1:0] ri;
  logic [WW-1:0] wi;

  assign first = (idx_r == '0);
  assign ci = idx_r[CW-1:0];
  assign ri = idx_r[RW-1:0];
  assign wi = idx_r[WW-1:0];
  assign dst_ok = (in_frame_dst_mac == BROADCAST_MAC) || (in_frame_dst_mac == own_mac_r);
  assign in_use = (32'(idx_r) < 32'(wcnt_r));

  always_comb begin
    killm = 1'b0;
    for (int k = 0; k < REQUEST_ENTRIES; k++) begin
      if (kill_r[k] && (r_ip_r[k] == w_ip_r[wi])) killm = 1'b1;
    end
  end
  assign drop = in_use && ((op_r == OP_TICK) ? killm : (w_ip_r[wi] == key_r));

  assign sts.op      = op_r;
  assign sts.deliver = dlv_r;
  assign sts.arp     = arp_r;
  assign sts.reply   = rep_r;
  assign sts.hit     = hit_r;
  assign sts.c_end   = (idx_r == IW'(CACHE_ENTRIES - 1));
  assign sts.r_end   = (idx_r == IW'(REQUEST_ENTRIES - 1));
  assign sts.w_end   = (idx_r == IW'(WAITING_ENTRIES - 1));

  always_comb begin
    own_mac_nxt = own_mac_r; own_ip_nxt = own_ip_r;
    ent_lt_nxt = ent_lt_r; req_lt_nxt = req_lt_r;
    op_nxt = op_r; key_nxt = key_r; dt_nxt = dt_r; mac_nxt = mac_r; tag_nxt = tag_r;
    dlv_nxt = dlv_r; arp_nxt = arp_r; rep_nxt = rep_r;
    c_val_nxt = c_val_r; c_ip_nxt = c_ip_r; c_mac_nxt = c_mac_r; c_ttl_nxt = c_ttl_r;
    r_val_nxt = r_val_r; kill_nxt = kill_r; r_ip_nxt = r_ip_r; r_ttl_nxt = r_ttl_r;
    w_ip_nxt = w_ip_r; w_tag_nxt = w_tag_r; wcnt_nxt = wcnt_r; wp_nxt = wp_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r; hit_idx_nxt = hit_idx_r; hit_mac_nxt = hit_mac_r;
    free_nxt = free_r; free_idx_nxt = free_idx_r;
    min_idx_nxt = min_idx_r; min_ttl_nxt = min_ttl_r;
    outs_nxt = outs_r; rfree_nxt = rfree_r; rfree_idx_nxt = rfree_idx_r;
    push = 1'b0; p_act = ACT_FRAME; p_mac = '0; p_ip = '0; p_tag = '0;
    slot = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_MAC:  own_mac_nxt = cfg_wdata;
        CFG_OWN_IP:   own_ip_nxt  = cfg_wdata[31:0];
        CFG_ENTRY_LT: ent_lt_nxt  = cfg_wdata[31:0];
        CFG_REQ_LT:   req_lt_nxt  = cfg_wdata[31:0];
        default: ;
      endcase
    end

    if (cmd.load) begin
      op_nxt  = in_operation;
      key_nxt = (in_operation == OP_SEND) ? in_hop_ip : in_arp_sender_ip;
      mac_nxt = in_arp_sender_mac;
      tag_nxt = in_packet_tag;
      dt_nxt  = in_elapsed_ms;
      dlv_nxt = dst_ok && in_parse_ok && (in_frame_kind == KIND_IPV4);
      arp_nxt = dst_ok && in_parse_ok && (in_frame_kind == KIND_ARP);
      rep_nxt = dst_ok && in_parse_ok && (in_frame_kind == KIND_ARP) &&
                (in_arp_op == ARP_OP_REQUEST) && (in_arp_target_ip == own_ip_r);
      kill_nxt = '0;
    end

    if (cmd.clr_idx) idx_nxt = '0;
    else if (cmd.scan_c || cmd.scan_r || cmd.scan_w) idx_nxt = idx_r + 1'b1;

    if (cmd.scan_c) begin
      if (op_r == OP_TICK) begin
        if (c_val_r[ci]) begin
          if (c_ttl_r[ci] <= dt_r) c_val_nxt[ci] = 1'b0;
          else c_ttl_nxt[ci] = c_ttl_r[ci] - dt_r;
        end
      end else begin
        hit_nxt  = first ? 1'b0 : hit_r;
        free_nxt = first ? 1'b0 : free_r;
        if (first || (c_ttl_r[ci] < min_ttl_r)) begin
          min_ttl_nxt = c_ttl_r[ci];
          min_idx_nxt = ci;
        end
        if (c_val_r[ci] && (c_ip_r[ci] == key_r) && !hit_nxt) begin
          hit_nxt = 1'b1; hit_idx_nxt = ci; hit_mac_nxt = c_mac_r[ci];
        end
        if (!c_val_r[ci] && !free_nxt) begin
          free_nxt = 1'b1; free_idx_nxt = ci;
        end
      end
    end

    if (cmd.scan_r) begin
      if (op_r == OP_TICK) begin
        if (r_val_r[ri]) begin
          if (r_ttl_r[ri] <= dt_r) begin
            r_val_nxt[ri] = 1'b0; kill_nxt[ri] = 1'b1;
          end else begin
            r_ttl_nxt[ri] = r_ttl_r[ri] - dt_r;
          end
        end
      end else begin
        outs_nxt  = (first ? 1'b0 : outs_r) || (r_val_r[ri] && (r_ip_r[ri] == key_r));
        rfree_nxt = first ? 1'b0 : rfree_r;
        if (!r_val_r[ri] && !rfree_nxt) begin
          rfree_nxt = 1'b1; rfree_idx_nxt = ri;
        end
      end
    end

    if (cmd.scan_w) begin
      wp_nxt = first ? '0 : wp_r;
      if (drop) begin
        if (op_r != OP_TICK) begin
          push = 1'b1; p_act = ACT_FRAME; p_mac = mac_r; p_tag = w_tag_r[wi];
        end
      end else if (in_use) begin
        w_ip_nxt[wp_nxt[WW-1:0]]  = w_ip_r[wi];
        w_tag_nxt[wp_nxt[WW-1:0]] = w_tag_r[wi];
        wp_nxt = wp_nxt + 1'b1;
      end
      if (sts.w_end) wcnt_nxt = wp_nxt;
    end

    if (cmd.do_learn) begin
      slot = hit_r ? hit_idx_r : (free_r ? free_idx_r : min_idx_r);
      c_val_nxt[slot] = 1'b1;
      c_ip_nxt[slot]  = key_r;
      c_mac_nxt[slot] = mac_r;
      c_ttl_nxt[slot] = ent_lt_r;
    end

    if (cmd.do_send) begin
      push = 1'b1;
      if (hit_r) begin
        p_act = ACT_FRAME; p_mac = hit_mac_r; p_tag = tag_r;
      end else if ((!outs_r && !rfree_r) || (wcnt_r == WCW'(WAITING_ENTRIES))) begin
        p_act = ACT_DROP; p_tag = tag_r;
      end else begin
        push = !outs_r;
        p_act = ACT_ARP_REQ; p_mac = BROADCAST_MAC; p_ip = key_r;
        if (!outs_r) begin
          r_val_nxt[rfree_idx_r] = 1'b1;
          r_ip_nxt[rfree_idx_r]  = key_r;
          r_ttl_nxt[rfree_idx_r] = req_lt_r;
        end
        w_ip_nxt[wcnt_r[WW-1:0]]  = key_r;
        w_tag_nxt[wcnt_r[WW-1:0]] = tag_r;
        wcnt_nxt = wcnt_r + 1'b1;
      end
    end

    if (cmd.push_reply) begin
      push = 1'b1; p_act = ACT_ARP_REPLY; p_mac = mac_r; p_ip = key_r;
    end
    if (cmd.push_deliver) begin
      push = 1'b1; p_act = ACT_DELIVER; p_tag = tag_r;
    end
  end

  // one-deep hold so the final beat of an item can be flagged
  always_comb begin
    hold_v_nxt = hold_v_r; hold_act_nxt = hold_act_r; hold_mac_nxt = hold_mac_r;
    hold_ip_nxt = hold_ip_r; hold_tag_nxt = hold_tag_r;
    o_stb_nxt = 1'b0; o_last_nxt = 1'b0;
    o_act_nxt = o_act_r; o_mac_nxt = o_mac_r; o_ip_nxt = o_ip_r; o_tag_nxt = o_tag_r;
    if ((push || cmd.flush) && hold_v_r) begin
      o_stb_nxt = 1'b1;
      o_last_nxt = cmd.flush;
      o_act_nxt = hold_act_r; o_mac_nxt = hold_mac_r;
      o_ip_nxt = hold_ip_r; o_tag_nxt = hold_tag_r;
    end
    if (cmd.flush) hold_v_nxt = 1'b0;
    if (push) begin
      hold_v_nxt = 1'b1; hold_act_nxt = p_act; hold_mac_nxt = p_mac;
      hold_ip_nxt = p_ip; hold_tag_nxt = p_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
      ent_lt_r  <= 32'd30000;
      req_lt_r  <= 32'd5000;
      c_val_r   <= '0;
      r_val_r   <= '0;
      kill_r    <= '0;
      wcnt_r    <= '0;
      wp_r      <= '0;
      idx_r     <= '0;
      hold_v_r  <= 1'b0;
      o_stb_r   <= 1'b0;
      o_last_r  <= 1'b0;
    end else begin
      own_mac_r <= own_mac_nxt;
      own_ip_r  <= own_ip_nxt;
      ent_lt_r  <= ent_lt_nxt;
      req_lt_r  <= req_lt_nxt;
      c_val_r   <= c_val_nxt;
      r_val_r   <= r_val_nxt;
      kill_r    <= kill_nxt;
      wcnt_r    <= wcnt_nxt;
      wp_r      <= wp_nxt;
      idx_r     <= idx_nxt;
      hold_v_r  <= hold_v_nxt;
      o_stb_r   <= o_stb_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; key_r <= key_nxt; dt_r <= dt_nxt; mac_r <= mac_nxt; tag_r <= tag_nxt;
    dlv_r <= dlv_nxt; arp_r <= arp_nxt; rep_r <= rep_nxt;
    c_ip_r <= c_ip_nxt; c_mac_r <= c_mac_nxt; c_ttl_r <= c_ttl_nxt;
    r_ip_r <= r_ip_nxt; r_ttl_r <= r_ttl_nxt;
    w_ip_r <= w_ip_nxt; w_tag_r <= w_tag_nxt;
    hit_r <= hit_nxt; hit_idx_r <= hit_idx_nxt; hit_mac_r <= hit_mac_nxt;
    free_r <= free_nxt; free_idx_r <= free_idx_nxt;
    min_idx_r <= min_idx_nxt; min_ttl_r <= min_ttl_nxt;
    outs_r <= outs_nxt; rfree_r <= rfree_nxt; rfree_idx_r <= rfree_idx_nxt;
    hold_act_r <= hold_act_nxt; hold_mac_r <= hold_mac_nxt;
    hold_ip_r <= hold_ip_nxt; hold_tag_r <= hold_tag_nxt;
    o_act_r <= o_act_nxt; o_mac_r <= o_mac_nxt; o_ip_r <= o_ip_nxt; o_tag_r <= o_tag_nxt;
  end

  assign out_strobe     = o_stb_r;
  assign out_last       = o_last_r;
  assign out_action     = o_act_r;
  assign out_dest_mac   = o_mac_r;
  assign out_ask_ip     = o_ip_r;
  assign out_result_tag = o_tag_r;

endmodule

/* sv/arp_resolver_with_aging_cache.sv */
// Top level of the ARP resolver with an aging IP-to-MAC cache.
// One item at a time: busy rises the cycle after start is taken and falls when
// the last result beat, if any, is driven. Each table is walked one entry per
// cycle: a send walks the cache and, on a miss, the request table; an accepted
// ARP message walks the cache and the waiting table; a tick walks all three
// tables; other frames walk none. Results come one beat per cycle at most on
// out_strobe and cannot be stalled; out_last marks the final beat of an item.
// Configuration is taken at any time via cfg_valid (cfg_ready is always high)
// but should only change while idle.
module arp_resolver_with_aging_cache import arpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [31:0]         in_hop_ip,
  input  logic [TAG_BITS-1:0] in_packet_tag,
  input  logic [47:0]         in_frame_dst_mac,
  input  logic [1:0]          in_frame_kind,
  input  logic                in_parse_ok,
  input  logic [1:0]          in_arp_op,
  input  logic [47:0]         in_arp_sender_mac,
  input  logic [31:0]         in_arp_sender_ip,
  input  logic [31:0]         in_arp_target_ip,
  input  logic [31:0]         in_elapsed_ms,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_wdata,
  output logic                out_strobe,
  output logic [2:0]          out_action,
  output logic [47:0]         out_dest_mac,
  output logic [31:0]         out_ask_ip,
  output logic [TAG_BITS-1:0] out_result_tag,
  output logic                out_last
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  arpc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_operation),
    .in_hop_ip         (in_hop_ip),
    .in_packet_tag     (in_packet_tag),
    .in_frame_dst_mac  (in_frame_dst_mac),
    .in_frame_kind     (in_frame_kind),
    .in_parse_ok       (in_parse_ok),
    .in_arp_op         (in_arp_op),
    .in_arp_sender_mac (in_arp_sender_mac),
    .in_arp_sender_ip  (in_arp_sender_ip),
    .in_arp_target_ip  (in_arp_target_ip),
    .in_elapsed_ms     (in_elapsed_ms),
    .out_strobe        (out_strobe),
    .out_action        (out_action),
    .out_dest_mac      (out_dest_mac),
    .out_ask_ip        (out_ask_ip),
    .out_result_tag    (out_result_tag),
    .out_last          (out_last)
  );

endmodule

/* sv/arpc_chk.sv */
// Port-level checker for the ARP resolver, bound to the top level.
`include "arp_resolver_with_aging_cache_macros.svh"

module arpc_chk import arpc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input logic [2:0]          out_action,
  input logic [47:0]         out_dest_mac,
  input logic [TAG_BITS-1:0] out_result_tag,
  input logic                out_last
);

  `ARPC_ASSERT_NEXT(a_take_busy, start && !busy, busy, "accepted item did not raise busy")
  `ARPC_ASSERT_NEXT(a_last_gap, out_strobe && out_last, !out_strobe, "beat straight after last")
  `ARPC_ASSERT_NOW(a_act_range, out_strobe, out_action <= ACT_DROP, "action code out of range")
  `ARPC_ASSERT_NOW(a_req_bcast, out_strobe && (out_action == ACT_ARP_REQ), (out_dest_mac == BROADCAST_MAC) && (out_result_tag == '0), "ARP request not broadcast")

endmodule

bind arp_resolver_with_aging_cache arpc_chk u_arpc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_action     (out_action),
  .out_dest_mac   (out_dest_mac),
  .out_result_tag (out_result_tag),
  .out_last       (out_last)
);

/* sim/tb_top.sv */
// Self-checking testbench for the ARP resolver with aging cache: directed and random traffic.
module tb_top import arpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0]          op;
    logic [31:0]         hop_ip;
    logic [TAG_BITS-1:0] tag;
    logic [47:0]         dst_mac;
    logic [1:0]          kind;
    logic                parse_ok;
    logic [1:0]          arp_op;
    logic [47:0]         s_mac;
    logic [31:0]         s_ip;
    logic [31:0]         t_ip;
    logic [31:0]         elapsed;
  } item_t;

  typedef struct {
    logic [2:0]          action;
    logic [47:0]         mac;
    logic [31:0]         ip;
    logic [TAG_BITS-1:0] tag;
    logic                last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]          in_operation = '0;
  logic [31:0]         in_hop_ip = '0;
  logic [TAG_BITS-1:0] in_packet_tag = '0;
  logic [47:0]         in_frame_dst_mac = '0;
  logic [1:0]          in_frame_kind = '0;
  logic                in_parse_ok = 1'b0;
  logic [1:0]          in_arp_op = '0;
  logic [47:0]         in_arp_sender_mac = '0;
  logic [31:0]         in_arp_sender_ip = '0;
  logic [31:0]         in_arp_target_ip = '0;
  logic [31:0]         in_elapsed_ms = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [47:0]         cfg_wdata = '0;
  logic                out_strobe;
  logic [2:0]          out_action;
  logic [47:0]         out_dest_mac;
  logic [31:0]         out_ask_ip;
  logic [TAG_BITS-1:0] out_result_tag;
  logic                out_last;

  arp_resolver_with_aging_cache u_top (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [47:0] m_own_mac;
  logic [31:0] m_own_ip, m_entry_lt, m_req_lt;
  logic        c_vld [CACHE_ENTRIES];
  logic [31:0] c_ip  [CACHE_ENTRIES];
  logic [47:0] c_mac [CACHE_ENTRIES];
  logic [31:0] c_ttl [CACHE_ENTRIES];
  logic        r_vld [REQUEST_ENTRIES];
  logic [31:0] r_ip  [REQUEST_ENTRIES];
  logic [31:0] r_ttl [REQUEST_ENTRIES];
  logic        w_vld [WAITING_ENTRIES];
  logic [31:0] w_ip  [WAITING_ENTRIES];
  logic [TAG_BITS-1:0] w_tag [WAITING_ENTRIES];
  int          w_ord [WAITING_ENTRIES];

  beat_t expected_beats[$];
  int    fails = 0;
  int    cycles = 0;
  int    burst_left = 0;
  logic [31:0] ip_pool [6];

  function automatic void push_beat(logic [2:0] a, logic [47:0] m, logic [31:0] ip,
                                    logic [TAG_BITS-1:0] t);
    beat_t b;
    b.action = a; b.mac = m; b.ip = ip; b.tag = t; b.last = 1'b0;
    expected_beats.push_back(b);
  endfunction

  function automatic void renumber_waiting();
    int rank [WAITING_ENTRIES];
    for (int i = 0; i < WAITING_ENTRIES; i++) begin
      rank[i] = 0;
      if (w_vld[i])
        for (int j = 0; j < WAITING_ENTRIES; j++)
          if (w_vld[j] && w_ord[j] < w_ord[i]) rank[i]++;
    end
    for (int i = 0; i < WAITING_ENTRIES; i++)
      if (w_vld[i]) w_ord[i] = rank[i];
  endfunction

  function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
    int slot = -1;
    for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++)
      if (c_vld[i] && c_ip[i] == ip) slot = i;
    for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++)
      if (!c_vld[i]) slot = i;
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < CACHE_ENTRIES; i++)
        if (c_ttl[i] < c_ttl[slot]) slot = i;
    end
    c_vld[slot] = 1'b1; c_ip[slot] = ip; c_mac[slot] = mac; c_ttl[slot] = m_entry_lt;
  endfunction

  function automatic void resolve_send(item_t it);
    logic outst = 1'b0;
    int rfree = -1, wfree = -1, cnt = 0;
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (c_vld[i] && c_ip[i] == it.hop_ip) begin
        push_beat(ACT_FRAME, c_mac[i], '0, it.tag);
        return;
      end
    for (int i = 0; i < REQUEST_ENTRIES; i++)
      if (r_vld[i] && r_ip[i] == it.hop_ip) outst = 1'b1;
    for (int i = REQUEST_ENTRIES - 1; i >= 0; i--)
      if (!r_vld[i]) rfree = i;
    for (int i = WAITING_ENTRIES - 1; i >= 0; i--)
      if (!w_vld[i]) wfree = i;
      else cnt++;
    if ((!outst && rfree < 0) || wfree < 0) begin
      push_beat(ACT_DROP, '0, '0, it.tag);
      return;
    end
    if (!outst) begin
      push_beat(ACT_ARP_REQ, BROADCAST_MAC, it.hop_ip, '0);
      r_vld[rfree] = 1'b1; r_ip[rfree] = it.hop_ip; r_ttl[rfree] = m_req_lt;
    end
    w_vld[wfree] = 1'b1; w_ip[wfree] = it.hop_ip; w_tag[wfree] = it.tag; w_ord[wfree] = cnt;
  endfunction

  function automatic void resolve_frame(item_t it);
    logic taken [WAITING_ENTRIES];
    int cnt = 0;
    if (it.dst_mac != BROADCAST_MAC && it.dst_mac != m_own_mac) return;
    if (!it.parse_ok) return;
    if (it.kind == KIND_IPV4) begin
      push_beat(ACT_DELIVER, '0, '0, it.tag);
      return;
    end
    if (it.kind != KIND_ARP) return;
    if (it.arp_op == ARP_OP_REQUEST && it.t_ip == m_own_ip)
      push_beat(ACT_ARP_REPLY, it.s_mac, it.s_ip, '0);
    learn_mapping(it.s_ip, it.s_mac);
    for (int i = 0; i < WAITING_ENTRIES; i++) begin
      taken[i] = 1'b0;
      if (w_vld[i]) cnt++;
    end
    for (int r = 0; r < cnt; r++)
      for (int i = 0; i < WAITING_ENTRIES; i++)
        if (w_vld[i] && w_ord[i] == r && w_ip[i] == it.s_ip) begin
          push_beat(ACT_FRAME, it.s_mac, '0, w_tag[i]);
          taken[i] = 1'b1;
        end
    for (int i = 0; i < WAITING_ENTRIES; i++)
      if (taken[i]) w_vld[i] = 1'b0;
    renumber_waiting();
  endfunction

  function automatic void age_tables(logic [31:0] dt);
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (c_vld[i]) begin
        if (c_ttl[i] <= dt) c_vld[i] = 1'b0;
        else c_ttl[i] -= dt;
      end
    for (int i = 0; i < REQUEST_ENTRIES; i++)
      if (r_vld[i]) begin
        if (r_ttl[i] <= dt) begin
          r_vld[i] = 1'b0;
          for (int j = 0; j < WAITING_ENTRIES; j++)
            if (w_vld[j] && w_ip[j] == r_ip[i]) w_vld[j] = 1'b0;
        end else begin
          r_ttl[i] -= dt;
        end
      end
    renumber_waiting();
  endfunction

  function automatic void predict_results(item_t it);
    int before_n = expected_beats.size();
    case (it.op)
      OP_SEND: resolve_send(it);
      OP_RECV: resolve_frame(it);
      OP_TICK: age_tables(it.elapsed);
      default: ;
    endcase
    if (expected_beats.size() > before_n)
      expected_beats[expected_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    beat_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n && out_strobe) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat action", out_action, 0);
      end else begin
        e = expected_beats.pop_front();
        if (out_action !== e.action) report("action", out_action, e.action);
        if (out_dest_mac !== e.mac) report("dest_mac", out_dest_mac, e.mac);
        if (out_ask_ip !== e.ip) report("ask_ip", out_ask_ip, e.ip);
        if (out_result_tag !== e.tag) report("result_tag", out_result_tag, e.tag);
        if (out_last !== e.last) report("last", out_last, e.last);
      end
    end
  end

  // call at a rising edge; returns at a rising edge
  task automatic send_item(item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    in_operation <= it.op;        in_hop_ip <= it.hop_ip;
    in_packet_tag <= it.tag;      in_frame_dst_mac <= it.dst_mac;
    in_frame_kind <= it.kind;     in_parse_ok <= it.parse_ok;
    in_arp_op <= it.arp_op;       in_arp_sender_mac <= it.s_mac;
    in_arp_sender_ip <= it.s_ip;  in_arp_target_ip <= it.t_ip;
    in_elapsed_ms <= it.elapsed;
    do @(posedge clk); while (busy);
    predict_results(it);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_MAC:  m_own_mac = val;
      CFG_OWN_IP:   m_own_ip = val[31:0];
      CFG_ENTRY_LT: m_entry_lt = val[31:0];
      default:      m_req_lt = val[31:0];
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [47:0] mac, logic [31:0] ip, logic [31:0] elt,
                           logic [31:0] rlt);
    wait_idle();
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_OWN_IP, {16'h0, ip});
    write_reg(CFG_ENTRY_LT, {16'h0, elt});
    write_reg(CFG_REQ_LT, {16'h0, rlt});
  endtask

  function automatic item_t blank_item(logic [1:0] op);
    item_t it;
    it.op = op; it.hop_ip = '0; it.tag = '0; it.dst_mac = '0; it.kind = KIND_ARP;
    it.parse_ok = 1'b1; it.arp_op = 2'd2; it.s_mac = '0; it.s_ip = '0; it.t_ip = '0;
    it.elapsed = '0;
    return it;
  endfunction

  function automatic item_t send_to(logic [31:0] ip, logic [TAG_BITS-1:0] t);
    item_t it = blank_item(OP_SEND);
    it.hop_ip = ip; it.tag = t;
    return it;
  endfunction

  function automatic item_t arp_from(logic [47:0] dst, logic [1:0] aop, logic [47:0] smac,
                                     logic [31:0] sip, logic [31:0] tip);
    item_t it = blank_item(OP_RECV);
    it.dst_mac = dst; it.arp_op = aop; it.s_mac = smac; it.s_ip = sip; it.t_ip = tip;
    return it;
  endfunction

  function automatic item_t tick_of(logic [31:0] dt);
    item_t it = blank_item(OP_TICK);
    it.elapsed = dt;
    return it;
  endfunction

  task automatic test_resolution();
    item_t it;
    configure(48'h02AA_BB00_0001, 32'h0A00_0001, 32'd30000, 32'd5000);
    send_item(send_to(32'hC0A8_0001, 16'h0001));
    send_item(send_to(32'hC0A8_0001, 16'hFFFF));
    send_item(arp_from(m_own_mac, 2'd2, 48'h0011_2233_4455, 32'hC0A8_0001, m_own_ip));
    send_item(send_to(32'hC0A8_0001, 16'h0000));
    send_item(arp_from(BROADCAST_MAC, ARP_OP_REQUEST, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFFF,
                       m_own_ip));
    send_item(arp_from(BROADCAST_MAC, ARP_OP_REQUEST, 48'h1, 32'h1, 32'h0A00_0002));
    send_item(arp_from(m_own_mac, 2'd3, 48'h2, 32'h2, m_own_ip));
    send_item(arp_from(m_own_mac, 2'd0, 48'h3, 32'h3, m_own_ip));
    it = blank_item(OP_RECV); it.dst_mac = m_own_mac; it.kind = KIND_IPV4; it.tag = 16'hA5A5;
    send_item(it);
    it.dst_mac = 48'h0000_0000_0001;
    send_item(it);
    it.dst_mac = m_own_mac; it.parse_ok = 1'b0;
    send_item(it);
    it.parse_ok = 1'b1; it.kind = 2'd2;
    send_item(it);
    it.kind = 2'd3;
    send_item(it);
    it = blank_item(2'd3);
    send_item(it);
    send_item(tick_of(32'd0));
    send_item(tick_of(32'hFFFF_FFFF));
  endtask

  task automatic test_full_tables();
    configure(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < REQUEST_ENTRIES + 2; i++)
      send_item(send_to(32'h0B00_0000 + i, i[15:0]));
    for (int i = 0; i < WAITING_ENTRIES; i++)
      send_item(send_to(32'h0B00_0000, 16'h100 + i[15:0]));
    send_item(arp_from(BROADCAST_MAC, 2'd2, 48'hABCD, 32'h0B00_0000, 32'h0));
    for (int i = 0; i < CACHE_ENTRIES + 2; i++) begin
      send_item(arp_from(BROADCAST_MAC, 2'd2, 48'h5000 + i, 32'h0C00_0000 + i, 32'h0));
      send_item(tick_of(32'd1));
    end
    send_item(tick_of(32'hFFFF_FFFF));
  endtask

  function automatic item_t random_item();
    item_t it;
    int pick = $urandom_range(0, 99);
    it.op = pick < 42 ? OP_SEND : pick < 82 ? OP_RECV : pick < 96 ? OP_TICK : 2'd3;
    it.hop_ip = $urandom_range(0, 7) == 0 ? $urandom : ip_pool[$urandom_range(0, 5)];
    it.tag = TAG_BITS'($urandom);
    case ($urandom_range(0, 5))
      0: it.dst_mac = 48'({$urandom, $urandom});
      1, 2: it.dst_mac = BROADCAST_MAC;
      default: it.dst_mac = m_own_mac;
    endcase
    pick = $urandom_range(0, 19);
    it.kind = pick < 13 ? KIND_ARP : pick < 17 ? KIND_IPV4 : 2'($urandom_range(2, 3));
    it.parse_ok = $urandom_range(0, 9) != 0;
    it.arp_op = 2'($urandom_range(0, 3));
    it.s_mac = 48'({$urandom, $urandom});
    it.s_ip = $urandom_range(0, 7) == 0 ? $urandom : ip_pool[$urandom_range(0, 5)];
    it.t_ip = $urandom_range(0, 1) ? m_own_ip : $urandom;
    it.elapsed = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 40);
    return it;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_item(random_item());
  endtask

  initial begin
    for (int i = 0; i < 6; i++) ip_pool[i] = $urandom;
    m_own_mac = '0; m_own_ip = '0; m_entry_lt = 32'd30000; m_req_lt = 32'd5000;
    for (int i = 0; i < CACHE_ENTRIES; i++) c_vld[i] = 1'b0;
    for (int i = 0; i < REQUEST_ENTRIES; i++) r_vld[i] = 1'b0;
    for (int i = 0; i < WAITING_ENTRIES; i++) w_vld[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_random(20);
    test_resolution();
    test_full_tables();
    configure(48'({$urandom, $urandom}), $urandom, 32'd60, 32'd25);
    test_random(60);
    configure(48'h0, 32'h0, 32'd1, 32'd1);
    test_random(30);
    configure(48'({$urandom, $urandom}), $urandom, 32'd30000, 32'd5000);
    test_random(60);
    wait_idle();
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
